>>> src/elc_pkg.sv
// Shared types and constants for the encoder angle correction block.
// No dependencies; the blend, top-level and testbench files import this package.
package elc_pkg;

  // Field widths fixed by the item format
  localparam int ANGLE_BITS = 16;
  localparam int OFFSET_W   = 16;
  localparam int INDEX_W    = 10;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 1;

  // Default table depth and reset value of the table size register
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int SIZE_RESET      = 1024;

  // Item operations
  localparam logic OP_CORRECT = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_ENABLE = 1'b1;

  // Per-stage control that travels with each item
  typedef struct packed {
    logic valid;  // stage holds an item
    logic corr;   // item is a correct-angle item
  } elc_ctl_t;

endpackage

>>> src/elc_ram.sv
// Generic simple RAM: one write port, two read ports, registered read data.
// Standalone; no package dependency.
module elc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> src/elc_blend.sv
// Interpolation and output stages: blend of two table entries, subtract
// from the angle, output register. Depends on elc_pkg.
module elc_blend (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                corr_en,
  input  elc_pkg::elc_ctl_t                   ctl2,
  input  logic [elc_pkg::ANGLE_BITS-1:0]      raw2,
  input  logic [elc_pkg::ANGLE_BITS-1:0]      frac2,
  input  logic [elc_pkg::OFFSET_W-1:0]        lo2,
  input  logic [elc_pkg::OFFSET_W-1:0]        hi2,
  output logic                                out_valid,
  output logic [elc_pkg::ANGLE_BITS-1:0]      corrected_angle,
  output logic signed [elc_pkg::OFFSET_W-1:0] applied_offset
);
  import elc_pkg::*;

  localparam int DW = OFFSET_W + 1;
  localparam int FW = ANGLE_BITS + 1;
  localparam int MW = DW + FW;
  localparam int SW = MW + 1;

  // stage 3: slope times fraction
  logic signed [DW-1:0] diff;
  logic signed [MW-1:0] mult;
  elc_ctl_t             ctl3;
  logic signed [MW-1:0] prod3;
  logic [OFFSET_W-1:0]  lo3;
  logic [ANGLE_BITS-1:0] raw3;

  // stage 4: rounding add and angle subtract
  logic signed [SW-1:0] sum;
  logic [OFFSET_W-1:0]  off;
  logic [ANGLE_BITS-1:0] corr;

  assign diff = $signed({hi2[OFFSET_W-1], hi2}) - $signed({lo2[OFFSET_W-1], lo2});
  assign mult = diff * $signed({1'b0, frac2});

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
    end else if (adv) begin
      ctl3 <= ctl2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod3 <= mult;
      lo3   <= lo2;
      raw3  <= raw2;
    end
  end

  // lo*2^A + (hi-lo)*f + half, then floor shift
  assign sum = $signed({{(SW-OFFSET_W-ANGLE_BITS){lo3[OFFSET_W-1]}}, lo3, ANGLE_BITS'(0)})
             + SW'(prod3)
             + $signed(SW'(1) << (ANGLE_BITS - 1));
  assign off  = sum[ANGLE_BITS +: OFFSET_W];
  assign corr = raw3 - ANGLE_BITS'(off);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl3.valid && ctl3.corr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (corr_en) begin
        corrected_angle <= corr;
        applied_offset  <= $signed(off);
      end else begin
        corrected_angle <= raw3;
        applied_offset  <= '0;
      end
    end
  end

  a_corr_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (ctl3.valid && ctl3.corr && adv) |=> out_valid)
    else $error("correct item in stage 3 did not reach the output");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(out_valid) && $stable(ctl3)))
    else $error("pipeline moved while stalled");

  a_zero_when_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !corr_en) |-> (applied_offset == '0))
    else $error("nonzero offset while correction disabled");

endmodule

>>> src/encoder_angle_lut_correction.sv
// Pipeline: 4 stages; an accepted item's result lands in the output register of stage 4.
// Throughput: one item per cycle unless the output holds a stalled item; write items use a slot and give no result.
// Stage 1 multiplies angle by table size, stage 2 reads both entries from the
// dual-read RAM, stage 3 multiplies slope by fraction, stage 4 rounds and subtracts.
// Reset clears valid bits, table size to 1024 (clamped to depth), correction off;
// table contents stay undefined until written, no clearing pass.
module encoder_angle_lut_correction #(
  parameter int TABLE_DEPTH = elc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input item channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic [elc_pkg::ANGLE_BITS-1:0]      rotor_angle,
  input  logic [elc_pkg::INDEX_W-1:0]         entry_index,
  input  logic signed [elc_pkg::OFFSET_W-1:0] entry_offset,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [elc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [elc_pkg::SIZE_W-1:0]          cfg_data,
  // result item channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [elc_pkg::ANGLE_BITS-1:0]      corrected_angle,
  output logic signed [elc_pkg::OFFSET_W-1:0] applied_offset
);
  import elc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);      // table address width
  localparam int NW = $clog2(TABLE_DEPTH + 1);  // holds the size itself
  localparam int PW = ANGLE_BITS + NW;          // angle * size product
  localparam int SIZE_RST = (SIZE_RESET > TABLE_DEPTH) ? TABLE_DEPTH : SIZE_RESET;

  // configuration: table size stored already clamped to [2, TABLE_DEPTH]
  logic [NW-1:0] size_use;
  logic [NW-1:0] size_next;
  logic          corr_en;

  // pipeline advance: the whole pipe moves unless the output holds a stalled item
  logic adv;

  // stage 1
  logic                  v1;
  logic                  op1;
  logic [INDEX_W-1:0]    idx1;
  logic [OFFSET_W-1:0]   off1;
  logic [ANGLE_BITS-1:0] raw1;
  logic [PW-1:0]         prod1;

  // stage 1 address decode
  logic [NW-1:0] lo_full;
  logic [AW-1:0] lo_addr;
  logic [AW-1:0] hi_addr;
  logic          idx_ok;
  logic          ram_we;

  // stage 2
  elc_ctl_t              ctl2;
  logic [ANGLE_BITS-1:0] raw2;
  logic [ANGLE_BITS-1:0] frac2;
  logic [OFFSET_W-1:0]   lo2;
  logic [OFFSET_W-1:0]   hi2;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // clamp out-of-range sizes on the way into the register
  always_comb begin
    if (cfg_data < SIZE_W'(2)) begin
      size_next = NW'(2);
    end else if (32'(cfg_data) > TABLE_DEPTH) begin
      size_next = NW'(TABLE_DEPTH);
    end else begin
      size_next = NW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_use <= NW'(SIZE_RST);
      corr_en  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TABLE_SIZE:  size_use <= size_next;
        REG_CORR_ENABLE: corr_en  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage 1: capture the item and scale the angle by the table size
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1   <= op;
      idx1  <= entry_index;
      off1  <= entry_offset;
      raw1  <= rotor_angle;
      prod1 <= PW'(rotor_angle) * PW'(size_use);
    end
  end

  // top bits pick the lower entry; the last entry wraps to entry 0
  assign lo_full = prod1[ANGLE_BITS +: NW];
  assign lo_addr = prod1[ANGLE_BITS +: AW];
  assign hi_addr = (lo_full == size_use - NW'(1)) ? '0 : lo_addr + AW'(1);

  // writes land at the same pipeline point as reads, so item order is kept;
  // drop writes beyond the table
  assign idx_ok = 32'(idx1) < TABLE_DEPTH;
  assign ram_we = adv && v1 && (op1 == OP_WRITE) && idx_ok;

  elc_ram #(
    .WIDTH (OFFSET_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (AW'(idx1)),
    .wdata   (off1),
    .re      (adv),
    .raddr_a (lo_addr),
    .raddr_b (hi_addr),
    .rdata_a (lo2),
    .rdata_b (hi2)
  );

  // stage 2: table data arrives from the RAM read register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else if (adv) begin
      ctl2.valid <= v1;
      ctl2.corr  <= (op1 == OP_CORRECT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      raw2  <= raw1;
      frac2 <= prod1[ANGLE_BITS-1:0];
    end
  end

  // stages 3 and 4: interpolate, subtract, output register
  elc_blend u_blend (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .corr_en         (corr_en),
    .ctl2            (ctl2),
    .raw2            (raw2),
    .frac2           (frac2),
    .lo2             (lo2),
    .hi2             (hi2),
    .out_valid       (out_valid),
    .corrected_angle (corrected_angle),
    .applied_offset  (applied_offset)
  );

  a_size_range: assert property (@(posedge clk) disable iff (rst)
    (size_use >= NW'(2)) && (32'(size_use) <= TABLE_DEPTH))
    else $error("table size register outside its clamped range");

  a_lo_in_table: assert property (@(posedge clk) disable iff (rst)
    (v1 && (op1 == OP_CORRECT)) |-> (lo_full < size_use))
    else $error("lower entry index beyond the table size in use");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(v1) && $stable(ctl2)))
    else $error("front stages moved while stalled");

endmodule

>>> sim/tb_encoder_angle_lut_correction.sv
`timescale 1ns / 1ps
// Self-checking testbench for encoder_angle_lut_correction: offset table load, angle
// correction with linear interpolation, table size clamping and pass-through mode.
// Depends on elc_pkg and the encoder_angle_lut_correction RTL; reads nothing else.
module tb_encoder_angle_lut_correction;
  import elc_pkg::*;

  // Quiet cycles tolerated before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // Cycles to let a write item clear the 4-stage pipe before a register write
  localparam int PIPE_SETTLE = 8;
  // Random part: four idling phases, each split into settings of equal length
  localparam int PHASES      = 4;
  localparam int SETTINGS_PER_PHASE = 5;
  localparam int ITEMS_PER_SETTING  = 33;
  localparam int SEND_IDLE_PCT  [PHASES] = '{0, 84, 0, 30};
  localparam int RECV_STALL_PCT [PHASES] = '{0, 0, 84, 30};

  // One predicted result item
  typedef struct packed {
    logic [ANGLE_BITS-1:0]      corrected;
    logic signed [OFFSET_W-1:0] applied;
  } angle_result_t;

  // Directed rows: predicted item, item with the result typed in, register write
  typedef enum logic [1:0] {ROW_ITEM, ROW_KNOWN, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic                   op;
    logic [ANGLE_BITS-1:0]  raw;
    logic [INDEX_W-1:0]     idx;
    logic [OFFSET_W-1:0]    off;
    logic [CFG_IDX_W-1:0]   creg;
    logic [SIZE_W-1:0]      cval;
    logic [ANGLE_BITS-1:0]  want_corr;
    logic [OFFSET_W-1:0]    want_off;
  } dir_row_t;

  // The table starts at reset config (1024 entries, correction off) with every
  // entry already loaded by the fill loop.
  localparam int N_DIRECTED = 25;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // pass-through right after reset, both angle extremes
    '{ROW_KNOWN, OP_CORRECT, 16'h0000, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h0000, 16'h0000},
    '{ROW_KNOWN, OP_CORRECT, 16'hFFFF, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'hFFFF, 16'h0000},
    // load offset extremes into the first two and the last entry
    '{ROW_ITEM,  OP_WRITE,   16'h0000, 10'd0,    16'h7FFF, REG_TABLE_SIZE,  11'd0, 16'h0000, 16'h0000},
    '{ROW_ITEM,  OP_WRITE,   16'hFFFF, 10'd1,    16'h8000, REG_TABLE_SIZE,  11'd0, 16'h0000, 16'h0000},
    '{ROW_ITEM,  OP_WRITE,   16'h0000, 10'd1023, 16'h8000, REG_TABLE_SIZE,  11'd0, 16'h0000, 16'h0000},
    '{ROW_REG,   OP_CORRECT, 16'h0000, 10'd0,    16'h0000, REG_CORR_ENABLE, 11'd1, 16'h0000, 16'h0000},
    // exact entry hits, no fraction
    '{ROW_KNOWN, OP_CORRECT, 16'h0000, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h8001, 16'h7FFF},
    '{ROW_KNOWN, OP_CORRECT, 16'h0040, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h8040, 16'h8000},
    // rounding tie halfway between the extremes, then wrap from last entry to 0
    '{ROW_ITEM,  OP_CORRECT, 16'h0020, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h0000, 16'h0000},
    '{ROW_ITEM,  OP_CORRECT, 16'hFFFF, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h0000, 16'h0000},
    '{ROW_KNOWN, OP_CORRECT, 16'hFFC0, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h7FC0, 16'h8000},
    // table size below range acts as 2
    '{ROW_REG,   OP_CORRECT, 16'h0000, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h0000, 16'h0000},
    '{ROW_KNOWN, OP_CORRECT, 16'h8000, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h0000, 16'h8000},
    '{ROW_ITEM,  OP_CORRECT, 16'hFFFF, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h0000, 16'h0000},
    '{ROW_REG,   OP_CORRECT, 16'h0000, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd1, 16'h0000, 16'h0000},
    '{ROW_ITEM,  OP_CORRECT, 16'h4000, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h0000, 16'h0000},
    // table size above range acts as the full depth
    '{ROW_REG,   OP_CORRECT, 16'h0000, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'h7FF, 16'h0000, 16'h0000},
    '{ROW_KNOWN, OP_CORRECT, 16'h0040, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h8040, 16'h8000},
    // odd size, fraction from a non-power-of-two product
    '{ROW_REG,   OP_CORRECT, 16'h0000, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd3, 16'h0000, 16'h0000},
    '{ROW_ITEM,  OP_CORRECT, 16'hAAAA, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h0000, 16'h0000},
    // write followed at once by a read of the same entry
    '{ROW_REG,   OP_CORRECT, 16'h0000, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd1024, 16'h0000, 16'h0000},
    '{ROW_ITEM,  OP_WRITE,   16'h0000, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h0000, 16'h0000},
    '{ROW_KNOWN, OP_CORRECT, 16'h0000, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h0000, 16'h0000},
    // correction switched off again
    '{ROW_REG,   OP_CORRECT, 16'h0000, 10'd0,    16'h0000, REG_CORR_ENABLE, 11'd0, 16'h0000, 16'h0000},
    '{ROW_KNOWN, OP_CORRECT, 16'h1234, 10'd0,    16'h0000, REG_TABLE_SIZE,  11'd0, 16'h1234, 16'h0000}
  };

  // DUT ports; the inputs are all known from time zero
  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic                       op           = OP_CORRECT;
  logic [ANGLE_BITS-1:0]      rotor_angle  = '0;
  logic [INDEX_W-1:0]         entry_index  = '0;
  logic signed [OFFSET_W-1:0] entry_offset = '0;
  logic                       cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index    = REG_TABLE_SIZE;
  logic [SIZE_W-1:0]          cfg_data     = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic [ANGLE_BITS-1:0]      corrected_angle;
  logic signed [OFFSET_W-1:0] applied_offset;

  // Shadow of the block: offset table and both registers at their reset values
  logic signed [OFFSET_W-1:0] offset_model [TABLE_DEPTH_DEF];
  logic [SIZE_W-1:0]          size_model   = SIZE_W'(SIZE_RESET);
  logic                       enable_model = 1'b0;

  // Results still owed by the block, oldest first
  angle_result_t due_results [$];

  // Typed-in result that goes with the item now on the bus
  bit            known_valid = 1'b0;
  angle_result_t known_result = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;
  bit took_in, took_out;

  encoder_angle_lut_correction dut (
    .clk, .rst,
    .in_valid, .in_stall, .op, .rotor_angle, .entry_index, .entry_offset,
    .cfg_we, .cfg_index, .cfg_data,
    .out_valid, .out_stall, .corrected_angle, .applied_offset
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the corrected angle for one correct item from the shadow state.
  function automatic angle_result_t predict_correction(input logic [ANGLE_BITS-1:0] raw);
    angle_result_t res;
    longint span, prod, lo_i, hi_i, frac, mix;
    res = '0;
    if (!enable_model) begin
      res.corrected = raw;
      return res;
    end
    // Clamp the size in use into 2..depth
    span = longint'(size_model);
    if (span < 2) span = 2;
    if (span > TABLE_DEPTH_DEF) span = TABLE_DEPTH_DEF;
    // Upper product bits pick the lower entry, lower bits are the fraction
    prod = longint'(raw) * span;
    lo_i = prod >>> ANGLE_BITS;
    frac = prod & ((longint'(1) << ANGLE_BITS) - 1);
    if (lo_i >= span) lo_i = span - 1;
    hi_i = (lo_i == span - 1) ? 0 : lo_i + 1;
    // Blend and round to nearest, ties up; the arithmetic shift is a floor
    mix = longint'(offset_model[lo_i]) * ((longint'(1) << ANGLE_BITS) - frac)
        + longint'(offset_model[hi_i]) * frac
        + (longint'(1) << (ANGLE_BITS - 1));
    res.applied   = OFFSET_W'(mix >>> ANGLE_BITS);
    res.corrected = raw - res.applied;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Present one item at the falling edge, hold it until accepted.
  task automatic send_item(input logic op_i, input logic [ANGLE_BITS-1:0] raw_i,
                           input logic [INDEX_W-1:0] idx_i, input logic [OFFSET_W-1:0] off_i,
                           input bit known_i, input angle_result_t known_val);
    // Insert random sender gaps
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    known_valid  = known_i;
    known_result = known_val;
    in_valid     <= 1'b1;
    op           <= op_i;
    rotor_angle  <= raw_i;
    entry_index  <= idx_i;
    entry_offset <= off_i;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed result, then let write items clear the pipe.
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [SIZE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver stalls at random, redrawn at every falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Sample both channels and the register port at the rising edge: update the
  // shadow, queue predictions, check results and watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      took_in  = in_valid && !in_stall;
      took_out = out_valid && !out_stall;
      if (cfg_we) begin
        if (cfg_index == REG_TABLE_SIZE) size_model = cfg_data;
        if (cfg_index == REG_CORR_ENABLE) enable_model = cfg_data[0];
      end
      if (took_in) begin
        if (op == OP_WRITE) begin
          offset_model[entry_index] = entry_offset;
        end else begin
          due_results.push_back(known_valid ? known_result : predict_correction(rotor_angle));
        end
      end
      if (took_out) begin
        if (due_results.size() == 0) begin
          note_mismatch("unexpected result", corrected_angle, 16'hxxxx);
        end else begin
          if (corrected_angle !== due_results[0].corrected)
            note_mismatch("corrected_angle", corrected_angle, due_results[0].corrected);
          if (applied_offset !== due_results[0].applied)
            note_mismatch("applied_offset", applied_offset, due_results[0].applied);
          void'(due_results.pop_front());
        end
      end
      quiet_cycles = (took_in || took_out) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_encoder_angle_lut_correction: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic                   r_op;
    logic [ANGLE_BITS-1:0]  r_raw;
    logic [INDEX_W-1:0]     r_idx;
    logic [OFFSET_W-1:0]    r_off;
    logic [SIZE_W-1:0]      r_size;
    dir_row_t               row;

    // Hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Load every entry so no correction ever reads an unwritten one
    for (int e = 0; e < TABLE_DEPTH_DEF; e++)
      send_item(OP_WRITE, ANGLE_BITS'($urandom), e[INDEX_W-1:0], OFFSET_W'($urandom),
                1'b0, '0);

    // Directed rows
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      case (row.kind)
        ROW_REG: begin
          settle_pipeline();
          write_reg(row.creg, row.cval);
        end
        ROW_KNOWN: begin
          send_item(row.op, row.raw, row.idx, row.off, 1'b1,
                    angle_result_t'{row.want_corr, row.want_off});
        end
        default: begin
          send_item(row.op, row.raw, row.idx, row.off, 1'b0, '0);
        end
      endcase
    end

    // Random part: each phase idles differently, each setting rewrites both registers
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct  = SEND_IDLE_PCT[ph];
      recv_stall_pct = RECV_STALL_PCT[ph];
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        settle_pipeline();
        // Favor the clamp edges and small tables, with a full random spread too
        case ($urandom_range(9))
          0:       r_size = 11'd0;
          1:       r_size = 11'd1;
          2:       r_size = 11'd2;
          3:       r_size = 11'h7FF;
          4:       r_size = 11'd1024;
          5:       r_size = 11'd1025;
          6, 7:    r_size = SIZE_W'($urandom_range(2, 64));
          default: r_size = SIZE_W'($urandom);
        endcase
        write_reg(REG_TABLE_SIZE, r_size);
        write_reg(REG_CORR_ENABLE, ($urandom_range(9) < 8) ? 11'd1 : 11'd0);
        for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
          // Hold the sender once per phase until the block has drained
          if (s == 2 && k == ITEMS_PER_SETTING / 2) settle_pipeline();
          r_op  = ($urandom_range(4) == 0) ? OP_WRITE : OP_CORRECT;
          r_raw = ANGLE_BITS'($urandom);
          if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
              0:       r_raw = 16'h0000;
              1:       r_raw = 16'hFFFF;
              2:       r_raw = 16'h8000;
              default: r_raw = 16'h7FFF;
            endcase
          end
          r_idx = INDEX_W'($urandom);
          r_off = OFFSET_W'($urandom);
          if ($urandom_range(7) == 0) r_off = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
          send_item(r_op, r_raw, r_idx, r_off, 1'b0, '0);
        end
      end
    end

    // Drain and let the pipe go quiet before the verdict
    settle_pipeline();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb_encoder_angle_lut_correction: PASS");
    end else begin
      $display("tb_encoder_angle_lut_correction: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/elc_pkg.sv
src/elc_ram.sv
src/elc_blend.sv
src/encoder_angle_lut_correction.sv
sim/tb_encoder_angle_lut_correction.sv
